### rtl/tpi_pkg.sv
// Shared types and constants for the three-phase interpolation evaluator.
// No dependencies; every other rtl file except tpi_mulrnd refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tpi_pkg;

    // result field width and pipeline depth (six compute stages + output register)
    localparam int OUT_W  = 32;
    localparam int STAGES = 7;

    typedef logic signed [OUT_W-1:0] out_word_t;

    localparam out_word_t OUT_MAX = 32'sh7FFF_FFFF;
    localparam out_word_t OUT_MIN = 32'sh8000_0000;

    // range checks on the phases, carried down the pipe next to the data
    typedef struct packed {
        logic a_low;    // p0 below zero
        logic a_high;   // p0 above one
        logic b_out;    // p1 outside [0,1]
    } phase_flags_t;

endpackage

`default_nettype wire

### rtl/tpi_mulrnd.sv
// Registered signed multiply with round-to-nearest (ties up) rescale.
// Standalone; used by tpi_datapath for every product stage.
`timescale 1ns / 1ps
`default_nettype none

module tpi_mulrnd #(
    parameter int AW    = 18,
    parameter int BW    = 18,
    parameter int SHIFT = 16,
    parameter int RW    = 18
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [AW-1:0] a,
    input  wire logic signed [BW-1:0] b,
    output logic signed [RW-1:0]      prod
);

    localparam int PW = AW + BW;
    localparam logic signed [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (SHIFT - 1);

    logic signed [PW-1:0] full;
    logic signed [RW-1:0] prod_next;
    logic signed [RW-1:0] prod_reg;

    // adding half then dropping SHIFT bits is floor((x + 2^(s-1)) / 2^s)
    assign full      = PW'(a) * PW'(b) + HALF;
    assign prod_next = full[SHIFT+RW-1:SHIFT];
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tpi_ctrl.sv
// Valid tracking and per-stage load enables for the evaluator pipeline.
// Depends on tpi_pkg for the stage count.
`timescale 1ns / 1ps
`default_nettype none

module tpi_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [tpi_pkg::STAGES-1:0]        load
);

    localparam int N = tpi_pkg::STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;

    // a stage loads when it is empty or its content moves on; bubbles fill under stall
    always_comb
    begin
        load[N-1] = !valid_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < N; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[N-1];

    // any empty stage lets a new word in
    a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !(&valid_reg) |-> in_ready)
        else $error("pipeline has a bubble but input is stalled");

    // words in flight change only by accepted input and delivered output
    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> $countones(valid_reg) == $countones($past(valid_reg))
            + ($past(in_valid && in_ready) ? 1 : 0)
            - ($past(out_valid && out_ready) ? 1 : 0))
        else $error("word lost or duplicated in pipeline");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && (&valid_reg) |=> (&valid_reg))
        else $error("stalled full pipeline dropped a word");

endmodule

`default_nettype wire

### rtl/tpi_datapath.sv
// Six-stage arithmetic pipe for g0 and the two constrained derivatives.
// Depends on tpi_pkg (flags, stage count) and tpi_mulrnd.
`timescale 1ns / 1ps
`default_nettype none

module tpi_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic [tpi_pkg::STAGES-2:0]          load,
    input  wire logic signed [FRAC_BITS+1:0]         phase_a,
    input  wire logic signed [FRAC_BITS+1:0]         phase_b,
    input  wire logic signed [FRAC_BITS+1:0]         phase_c,
    output logic signed [FRAC_BITS+7:0]              g_raw,
    output logic signed [FRAC_BITS+9:0]              d0_raw,
    output logic signed [FRAC_BITS+10:0]             d1_raw,
    output tpi_pkg::phase_flags_t                    flags
);

    localparam int F   = FRAC_BITS;
    localparam int IW  = F + 2;     // input phase
    localparam int DW  = F + 3;     // phase difference
    localparam int W2  = F + 2;     // values in [-2,2)
    localparam int W4  = F + 4;
    localparam int W5  = F + 5;
    localparam int SQW = F + 6;     // squared difference, t1, t2
    localparam int UW  = F + 7;
    localparam int SW  = F + 8;     // u + v
    localparam int KW  = F + 5;     // 15 k
    localparam int DPW = F + 10;    // dp0 polynomial
    localparam int MW  = F + 6;
    localparam int INW = F + 10;    // 15 t2 + t3
    localparam int GW  = F + 8;
    localparam int D1W = F + 11;

    localparam logic signed [W4-1:0]  ONE4  = W4'(1) << F;
    localparam logic signed [W5-1:0]  ONE5  = W5'(1) << F;
    localparam logic signed [SQW-1:0] ONE6  = SQW'(1) << F;

    // ---------------- stage 1: differences and linear terms
    logic signed [W4-1:0] a4, b4, c4;
    logic signed [DW-1:0] s1_dbc_next, s1_dca_next;
    logic signed [W2-1:0] s1_oma_next, s1_omb_next, s1_ka_next, s1_kb_next;
    logic signed [W4-1:0] s1_kap_next, s1_kbp_next, s1_a5_next, s1_b5_next;
    tpi_pkg::phase_flags_t s1_flags_next;

    logic signed [IW-1:0] s1_a_reg, s1_b_reg;
    logic signed [DW-1:0] s1_dbc_reg, s1_dca_reg;
    logic signed [W2-1:0] s1_oma_reg, s1_omb_reg, s1_ka_reg, s1_kb_reg;
    logic signed [W4-1:0] s1_kap_reg, s1_kbp_reg, s1_a5_reg, s1_b5_reg;
    tpi_pkg::phase_flags_t s1_flags_reg;

    always_comb
    begin
        a4 = W4'(phase_a);
        b4 = W4'(phase_b);
        c4 = W4'(phase_c);
        s1_dbc_next = DW'(c4 - b4);
        s1_dca_next = DW'(c4 - a4);
        s1_oma_next = W2'(ONE4 - a4);
        s1_omb_next = W2'(ONE4 - b4);
        // 3x - 2 and 3x + 2; only meaningful for x in [0,1]
        s1_ka_next  = W2'((a4 <<< 1) + a4 - (ONE4 <<< 1));
        s1_kb_next  = W2'((b4 <<< 1) + b4 - (ONE4 <<< 1));
        s1_kap_next = (a4 <<< 1) + a4 + (ONE4 <<< 1);
        s1_kbp_next = (b4 <<< 1) + b4 + (ONE4 <<< 1);
        s1_a5_next  = (a4 <<< 2) + a4;
        s1_b5_next  = (b4 <<< 2) + b4;
        s1_flags_next.a_low  = phase_a[IW-1];
        s1_flags_next.a_high = a4 > ONE4;
        s1_flags_next.b_out  = b4[W4-1] || (b4 > ONE4);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_a_reg     <= phase_a;
            s1_b_reg     <= phase_b;
            s1_dbc_reg   <= s1_dbc_next;
            s1_dca_reg   <= s1_dca_next;
            s1_oma_reg   <= s1_oma_next;
            s1_omb_reg   <= s1_omb_next;
            s1_ka_reg    <= s1_ka_next;
            s1_kb_reg    <= s1_kb_next;
            s1_kap_reg   <= s1_kap_next;
            s1_kbp_reg   <= s1_kbp_next;
            s1_a5_reg    <= s1_a5_next;
            s1_b5_reg    <= s1_b5_next;
            s1_flags_reg <= s1_flags_next;
        end
    end

    // ---------------- stage 2: squares
    logic signed [SQW-1:0] s2_dbc_sq, s2_dca_sq;
    logic signed [W2-1:0]  s2_oma_sq, s2_omb_sq, s2_asq, s2_bsq;

    tpi_mulrnd #(.AW(DW), .BW(DW), .SHIFT(F), .RW(SQW)) u_dbc_sq (
        .clk(clk), .en(load[1]), .a(s1_dbc_reg), .b(s1_dbc_reg), .prod(s2_dbc_sq));
    tpi_mulrnd #(.AW(DW), .BW(DW), .SHIFT(F), .RW(SQW)) u_dca_sq (
        .clk(clk), .en(load[1]), .a(s1_dca_reg), .b(s1_dca_reg), .prod(s2_dca_sq));
    tpi_mulrnd #(.AW(W2), .BW(W2), .SHIFT(F), .RW(W2)) u_oma_sq (
        .clk(clk), .en(load[1]), .a(s1_oma_reg), .b(s1_oma_reg), .prod(s2_oma_sq));
    tpi_mulrnd #(.AW(W2), .BW(W2), .SHIFT(F), .RW(W2)) u_omb_sq (
        .clk(clk), .en(load[1]), .a(s1_omb_reg), .b(s1_omb_reg), .prod(s2_omb_sq));
    tpi_mulrnd #(.AW(IW), .BW(IW), .SHIFT(F), .RW(W2)) u_asq (
        .clk(clk), .en(load[1]), .a(s1_a_reg), .b(s1_a_reg), .prod(s2_asq));
    tpi_mulrnd #(.AW(IW), .BW(IW), .SHIFT(F), .RW(W2)) u_bsq (
        .clk(clk), .en(load[1]), .a(s1_b_reg), .b(s1_b_reg), .prod(s2_bsq));

    logic signed [IW-1:0] s2_a_reg;
    logic signed [DW-1:0] s2_dca_reg;
    logic signed [W2-1:0] s2_oma_reg, s2_omb_reg, s2_ka_reg, s2_kb_reg;
    logic signed [W4-1:0] s2_kap_reg, s2_kbp_reg, s2_a5_reg, s2_b5_reg;
    tpi_pkg::phase_flags_t s2_flags_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_a_reg     <= s1_a_reg;
            s2_dca_reg   <= s1_dca_reg;
            s2_oma_reg   <= s1_oma_reg;
            s2_omb_reg   <= s1_omb_reg;
            s2_ka_reg    <= s1_ka_reg;
            s2_kb_reg    <= s1_kb_reg;
            s2_kap_reg   <= s1_kap_reg;
            s2_kbp_reg   <= s1_kbp_reg;
            s2_a5_reg    <= s1_a5_reg;
            s2_b5_reg    <= s1_b5_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    // ---------------- stage 3: u, v, k products; t1 and 9a^2 - 5
    logic signed [UW-1:0] s3_ua, s3_ub;
    logic signed [W4-1:0] s3_va, s3_vb;
    logic signed [W2-1:0] s3_k;

    tpi_mulrnd #(.AW(SQW), .BW(W2), .SHIFT(F), .RW(UW)) u_ua (
        .clk(clk), .en(load[2]), .a(s2_dbc_sq), .b(s2_ka_reg), .prod(s3_ua));
    tpi_mulrnd #(.AW(W2), .BW(W4), .SHIFT(F), .RW(W4)) u_va (
        .clk(clk), .en(load[2]), .a(s2_oma_sq), .b(s2_kap_reg), .prod(s3_va));
    tpi_mulrnd #(.AW(SQW), .BW(W2), .SHIFT(F), .RW(UW)) u_ub (
        .clk(clk), .en(load[2]), .a(s2_dca_sq), .b(s2_kb_reg), .prod(s3_ub));
    tpi_mulrnd #(.AW(W2), .BW(W4), .SHIFT(F), .RW(W4)) u_vb (
        .clk(clk), .en(load[2]), .a(s2_omb_sq), .b(s2_kbp_reg), .prod(s3_vb));
    tpi_mulrnd #(.AW(W2), .BW(W2), .SHIFT(F), .RW(W2)) u_k (
        .clk(clk), .en(load[2]), .a(s2_bsq), .b(s2_omb_reg), .prod(s3_k));

    logic signed [SQW-1:0] s3_t1_next, s3_t1_reg;
    logic signed [W5-1:0]  asq5;
    logic signed [W4-1:0]  s3_gk_next, s3_gk_reg;
    logic signed [IW-1:0]  s3_a_reg;
    logic signed [W2-1:0]  s3_asq_reg, s3_oma_reg;
    logic signed [W4-1:0]  s3_a5_reg, s3_b5_reg;
    logic signed [DW-1:0]  s3_dca_reg;
    tpi_pkg::phase_flags_t s3_flags_reg;

    always_comb
    begin
        s3_t1_next = ONE6 + SQW'(s2_a_reg) - s2_dbc_sq;
        asq5       = W5'(s2_asq);
        s3_gk_next = W4'((asq5 <<< 3) + asq5 - ((ONE5 <<< 2) + ONE5));
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_t1_reg    <= s3_t1_next;
            s3_gk_reg    <= s3_gk_next;
            s3_a_reg     <= s2_a_reg;
            s3_asq_reg   <= s2_asq;
            s3_oma_reg   <= s2_oma_reg;
            s3_a5_reg    <= s2_a5_reg;
            s3_b5_reg    <= s2_b5_reg;
            s3_dca_reg   <= s2_dca_reg;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    // ---------------- stage 4: t2, t3 products; u + v sums; 15 k
    logic signed [SQW-1:0] s4_t2;
    logic signed [W4-1:0]  s4_t3;

    tpi_mulrnd #(.AW(W2), .BW(SQW), .SHIFT(F), .RW(SQW)) u_t2 (
        .clk(clk), .en(load[3]), .a(s3_oma_reg), .b(s3_t1_reg), .prod(s4_t2));
    tpi_mulrnd #(.AW(IW), .BW(W4), .SHIFT(F), .RW(W4)) u_t3 (
        .clk(clk), .en(load[3]), .a(s3_a_reg), .b(s3_gk_reg), .prod(s4_t3));

    logic signed [SW-1:0] s4_sa_next, s4_sb_next, s4_sa_reg, s4_sb_reg;
    logic signed [KW-1:0] s4_k15_next, s4_k15_reg;
    logic signed [W2-1:0] s4_asq_reg;
    logic signed [W4-1:0] s4_a5_reg, s4_b5_reg;
    logic signed [DW-1:0] s4_dca_reg;
    tpi_pkg::phase_flags_t s4_flags_reg;

    always_comb
    begin
        s4_sa_next  = SW'(s3_ua) + SW'(s3_va);
        s4_sb_next  = SW'(s3_ub) + SW'(s3_vb);
        s4_k15_next = (KW'(s3_k) <<< 4) - KW'(s3_k);
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_sa_reg    <= s4_sa_next;
            s4_sb_reg    <= s4_sb_next;
            s4_k15_reg   <= s4_k15_next;
            s4_asq_reg   <= s3_asq_reg;
            s4_a5_reg    <= s3_a5_reg;
            s4_b5_reg    <= s3_b5_reg;
            s4_dca_reg   <= s3_dca_reg;
            s4_flags_reg <= s3_flags_reg;
        end
    end

    // ---------------- stage 5: dp0(p0), dp0(p1), m products; inner sum
    logic signed [DPW-1:0] s5_dp0, s5_h;
    logic signed [MW-1:0]  s5_m;

    // x * 5 (u + v) / 2^(F+1): the 5/2 factor, with 5x formed in stage 1
    tpi_mulrnd #(.AW(W4), .BW(SW), .SHIFT(F + 1), .RW(DPW)) u_dp0 (
        .clk(clk), .en(load[4]), .a(s4_a5_reg), .b(s4_sa_reg), .prod(s5_dp0));
    tpi_mulrnd #(.AW(W4), .BW(SW), .SHIFT(F + 1), .RW(DPW)) u_h (
        .clk(clk), .en(load[4]), .a(s4_b5_reg), .b(s4_sb_reg), .prod(s5_h));
    tpi_mulrnd #(.AW(KW), .BW(DW), .SHIFT(F + 1), .RW(MW)) u_m (
        .clk(clk), .en(load[4]), .a(s4_k15_reg), .b(s4_dca_reg), .prod(s5_m));

    logic signed [INW-1:0] s5_inner_next, s5_inner_reg;
    logic signed [W2-1:0]  s5_asq_reg;
    tpi_pkg::phase_flags_t s5_flags_reg;

    assign s5_inner_next = (INW'(s4_t2) <<< 4) - INW'(s4_t2) + INW'(s4_t3);

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_inner_reg <= s5_inner_next;
            s5_asq_reg   <= s4_asq_reg;
            s5_flags_reg <= s4_flags_reg;
        end
    end

    // ---------------- stage 6: g0 product; dp1 combine
    tpi_mulrnd #(.AW(W2), .BW(INW), .SHIFT(F + 2), .RW(GW)) u_g (
        .clk(clk), .en(load[5]), .a(s5_asq_reg), .b(s5_inner_reg), .prod(g_raw));

    logic signed [D1W-1:0] neg_h;
    logic signed [D1W-1:0] s6_d1_next, s6_d1_reg;
    logic signed [DPW-1:0] s6_d0_reg;
    tpi_pkg::phase_flags_t s6_flags_reg;

    // round(-h / 2) ties up, plus m
    always_comb
    begin
        neg_h      = D1W'(1) - D1W'(s5_h);
        s6_d1_next = (neg_h >>> 1) + D1W'(s5_m);
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            s6_d1_reg    <= s6_d1_next;
            s6_d0_reg    <= s5_dp0;
            s6_flags_reg <= s5_flags_reg;
        end
    end

    assign d0_raw = s6_d0_reg;
    assign d1_raw = s6_d1_reg;
    assign flags  = s6_flags_reg;

endmodule

`default_nettype wire

### rtl/tpi_out.sv
// Output stage: range gating, saturation to 32 bits, output register.
// Depends on tpi_pkg for the result type and the flag struct.
`timescale 1ns / 1ps
`default_nettype none

module tpi_out #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire logic signed [FRAC_BITS+7:0]  g_raw,
    input  wire logic signed [FRAC_BITS+9:0]  d0_raw,
    input  wire logic signed [FRAC_BITS+10:0] d1_raw,
    input  wire tpi_pkg::phase_flags_t        flags,
    output tpi_pkg::out_word_t                interp_value,
    output tpi_pkg::out_word_t                deriv_first,
    output tpi_pkg::out_word_t                deriv_second
);

    localparam int XW = (FRAC_BITS + 11 > tpi_pkg::OUT_W + 1) ?
                        FRAC_BITS + 11 : tpi_pkg::OUT_W + 1;
    localparam tpi_pkg::out_word_t ONE_OUT = tpi_pkg::out_word_t'(1) << FRAC_BITS;

    function automatic tpi_pkg::out_word_t sat_word(input logic signed [XW-1:0] v);
        tpi_pkg::out_word_t r;
        if (v > XW'(tpi_pkg::OUT_MAX))
            r = tpi_pkg::OUT_MAX;
        else if (v < XW'(tpi_pkg::OUT_MIN))
            r = tpi_pkg::OUT_MIN;
        else
            r = v[tpi_pkg::OUT_W-1:0];
        return r;
    endfunction

    tpi_pkg::out_word_t g_next, d0_next, d1_next;
    tpi_pkg::out_word_t g_reg, d0_reg, d1_reg;

    always_comb
    begin
        g_next  = sat_word(XW'(g_raw));
        d0_next = sat_word(XW'(d0_raw));
        d1_next = flags.b_out ? '0 : sat_word(XW'(d1_raw));
        if (flags.a_low)
        begin
            g_next  = '0;
            d0_next = '0;
            d1_next = '0;
        end
        else if (flags.a_high)
        begin
            g_next  = ONE_OUT;
            d0_next = '0;
            d1_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            g_reg  <= g_next;
            d0_reg <= d0_next;
            d1_reg <= d1_next;
        end
    end

    assign interp_value = g_reg;
    assign deriv_first  = d0_reg;
    assign deriv_second = d1_reg;

    a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        load && flags.a_low |=> interp_value == '0 && deriv_first == '0
            && deriv_second == '0)
        else $error("negative p0 must give all-zero result");

    a_high_one: assert property (@(posedge clk) disable iff (!rst_n)
        load && !flags.a_low && flags.a_high |=> interp_value == ONE_OUT
            && deriv_first == '0 && deriv_second == '0)
        else $error("p0 above one must give g0 = 1 and zero derivatives");

    a_b_gate: assert property (@(posedge clk) disable iff (!rst_n)
        load && flags.b_out |=> deriv_second == '0)
        else $error("p1 outside [0,1] must zero the p1 derivative");

endmodule

`default_nettype wire

### rtl/three_phase_interpolation_eval_top.sv
// Three-phase interpolation evaluator, top level.
// Depends on tpi_pkg, tpi_ctrl, tpi_datapath, tpi_out (and tpi_mulrnd below it).
//
// Usage:
//   Slave side s_axis_*: one word per grid point carrying p0, p1, p2 as signed
//   Q2.FRAC_BITS phase fractions. Master side m_axis_*: one word per input word
//   with g0 and its constrained derivatives by p0 and p1, signed, FRAC_BITS
//   fraction bits, saturated to 32 bits.
//   Pipeline: seven register stages, the six compute stages of tpi_datapath
//   and the output register of tpi_out.
//   Throughput: one word per cycle while m_axis_tready is high; every stage is
//   registered and holds one word, so a new word can enter each cycle.
//   Stall: each stage loads when empty or when its word moves on, so while
//   m_axis_tready is low, empty stages keep filling and s_axis_tready drops only
//   once all seven stages hold a word. Nothing is lost or repeated.
//   Reset: rst_n clears all valid bits; the pipe comes up empty and ready, and
//   the data registers are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module three_phase_interpolation_eval_top #(
    parameter int FRAC_BITS = 16,
    localparam int IN_W  = FRAC_BITS + 2,
    localparam int IN_DW = ((3 * IN_W + 7) / 8) * 8,
    localparam int OUT_DW = 3 * tpi_pkg::OUT_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // phase_a, phase_b, phase_c (IN_W bits each), zero pad at top
    input  wire logic [IN_DW-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // interp_value, deriv_first, deriv_second (32 bits each)
    output logic [OUT_DW-1:0]      m_axis_tdata
);

    logic [tpi_pkg::STAGES-1:0] load;

    logic signed [IN_W-1:0]         phase_a, phase_b, phase_c;
    logic signed [FRAC_BITS+7:0]    g_raw;
    logic signed [FRAC_BITS+9:0]    d0_raw;
    logic signed [FRAC_BITS+10:0]   d1_raw;
    tpi_pkg::phase_flags_t          flags;
    tpi_pkg::out_word_t             interp_value, deriv_first, deriv_second;

    assign phase_a = s_axis_tdata[IN_W-1:0];
    assign phase_b = s_axis_tdata[2*IN_W-1:IN_W];
    assign phase_c = s_axis_tdata[3*IN_W-1:2*IN_W];

    tpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .load      (load)
    );

    tpi_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
        .clk     (clk),
        .load    (load[tpi_pkg::STAGES-2:0]),
        .phase_a (phase_a),
        .phase_b (phase_b),
        .phase_c (phase_c),
        .g_raw   (g_raw),
        .d0_raw  (d0_raw),
        .d1_raw  (d1_raw),
        .flags   (flags)
    );

    tpi_out #(.FRAC_BITS(FRAC_BITS)) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load[tpi_pkg::STAGES-1]),
        .g_raw        (g_raw),
        .d0_raw       (d0_raw),
        .d1_raw       (d1_raw),
        .flags        (flags),
        .interp_value (interp_value),
        .deriv_first  (deriv_first),
        .deriv_second (deriv_second)
    );

    assign m_axis_tdata = {deriv_second, deriv_first, interp_value};

endmodule

`default_nettype wire

### tb/sv/tpi_result_checker.sv
// Result checker for the three-phase interpolation evaluator: watches both stream
// channels, predicts g0 and its constrained derivatives, compares in order.
// Depends on tpi_pkg for the result word type and saturation bounds.
`timescale 1ns / 1ps

module tpi_result_checker #(
    parameter int FRAC_BITS = 16,
    localparam int IN_W  = FRAC_BITS + 2,
    localparam int IN_DW = ((3 * IN_W + 7) / 8) * 8,
    localparam int OUT_DW = 3 * tpi_pkg::OUT_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    // phase_a, phase_b, phase_c (IN_W bits each), zero pad at top
    input  wire logic [IN_DW-1:0]  s_tdata,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    // interp_value, deriv_first, deriv_second (32 bits each)
    input  wire logic [OUT_DW-1:0] m_tdata,
    output int                     error_count,
    output int                     open_count,
    output int                     result_count
);

    localparam longint UNIT = longint'(1) << FRAC_BITS;
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        tpi_pkg::out_word_t value;
        tpi_pkg::out_word_t d_first;
        tpi_pkg::out_word_t d_second;
    } interp_result_t;

    interp_result_t interp_q[$];
    int errors = 0;
    int results = 0;
    int pending = 0;

    assign error_count  = errors;
    assign open_count   = pending;
    assign result_count = results;

    // round to nearest, ties toward +inf; arithmetic shift gives the floor
    function automatic longint round_shift(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic tpi_pkg::out_word_t saturate(longint v);
        if (v > longint'(tpi_pkg::OUT_MAX))
            return tpi_pkg::OUT_MAX;
        if (v < longint'(tpi_pkg::OUT_MIN))
            return tpi_pkg::OUT_MIN;
        return tpi_pkg::out_word_t'(v);
    endfunction

    // d g0 / d x polynomial, x in [0,1]
    function automatic longint deriv_poly(longint x, longint y, longint z);
        longint d, dsq, u, om, omsq, v;
        d    = z - y;
        dsq  = round_shift(d * d, FRAC_BITS);
        u    = round_shift(dsq * (3 * x - 2 * UNIT), FRAC_BITS);
        om   = UNIT - x;
        omsq = round_shift(om * om, FRAC_BITS);
        v    = round_shift(omsq * (3 * x + 2 * UNIT), FRAC_BITS);
        return round_shift(x * (5 * (u + v)), FRAC_BITS + 1);
    endfunction

    function automatic longint interp_poly(longint a, longint b, longint c);
        longint d, dsq, t1, t2, asq, t3, inner;
        d     = c - b;
        dsq   = round_shift(d * d, FRAC_BITS);
        t1    = UNIT + a - dsq;
        t2    = round_shift((UNIT - a) * t1, FRAC_BITS);
        asq   = round_shift(a * a, FRAC_BITS);
        t3    = round_shift(a * (9 * asq - 5 * UNIT), FRAC_BITS);
        inner = 15 * t2 + t3;
        return round_shift(asq * inner, FRAC_BITS + 2);
    endfunction

    function automatic interp_result_t predict_interp(logic [IN_DW-1:0] word);
        logic signed [IN_W-1:0] pa, pb, pc;
        longint a, b, c, g, d0, d1, h, bsq, k, m;
        interp_result_t r;
        pa = word[IN_W-1:0];
        pb = word[2*IN_W-1:IN_W];
        pc = word[3*IN_W-1:2*IN_W];
        a = longint'(pa);
        b = longint'(pb);
        c = longint'(pc);
        g = 0;
        d0 = 0;
        d1 = 0;
        if (a > UNIT)
            g = UNIT;
        else if (a >= 0)
        begin
            g  = interp_poly(a, b, c);
            d0 = deriv_poly(a, b, c);
            if (b >= 0 && b <= UNIT)
            begin
                // p1 derivative reuses the p0 one with p0 and p1 swapped
                h   = deriv_poly(b, a, c);
                bsq = round_shift(b * b, FRAC_BITS);
                k   = round_shift(bsq * (UNIT - b), FRAC_BITS);
                m   = round_shift(15 * k * (c - a), FRAC_BITS + 1);
                d1  = round_shift(-h, 1) + m;
            end
        end
        r.value    = saturate(g);
        r.d_first  = saturate(d0);
        r.d_second = saturate(d1);
        return r;
    endfunction

    task automatic report_error(string msg);
        if (errors < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(string field, tpi_pkg::out_word_t got,
                               tpi_pkg::out_word_t want);
        if (got !== want)
            report_error($sformatf("word %0d %s: got %0d, want %0d",
                                   results, field, got, want));
    endtask

    always @(posedge clk)
    begin
        interp_result_t want;
        if (rst_n)
        begin
            // pop before push: a word never leaves at the edge it entered
            if (m_tvalid && m_tready)
            begin
                if (interp_q.size() == 0)
                    report_error($sformatf("unexpected output word %h", m_tdata));
                else
                begin
                    want = interp_q.pop_front();
                    check_field("interp_value", m_tdata[31:0], want.value);
                    check_field("deriv_first", m_tdata[63:32], want.d_first);
                    check_field("deriv_second", m_tdata[95:64], want.d_second);
                end
                results++;
            end
            if (s_tvalid && s_tready)
                interp_q.push_back(predict_interp(s_tdata));
            pending <= interp_q.size();
        end
    end

endmodule

### tb/sv/testbench.sv
// Top of the three-phase interpolation evaluator bench: clock, reset, stimulus and
// output backpressure. Depends on tpi_pkg, the evaluator top and tpi_result_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC_BITS = 16;
    localparam int IN_W  = FRAC_BITS + 2;
    localparam int IN_DW = ((3 * IN_W + 7) / 8) * 8;
    localparam int OUT_DW = 3 * tpi_pkg::OUT_W;
    localparam int UNIT = 1 << FRAC_BITS;
    localparam int PMIN = -(1 << (IN_W - 1));
    localparam int PMAX = (1 << (IN_W - 1)) - 1;
    localparam int PHASE_ITEMS = 350;
    localparam int STALL_LEN = 64;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;

    int error_count, open_count, result_count;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int sent_count = 0;
    int cycle_count = 0;
    int stall_cycles = 0;
    logic long_stall_go = 1'b0;
    logic long_stall_done = 1'b0;

    always #4 clk = ~clk;

    three_phase_interpolation_eval_top #(.FRAC_BITS(FRAC_BITS)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    tpi_result_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .error_count  (error_count),
        .open_count   (open_count),
        .result_count (result_count)
    );

    // receiver: random idling, plus one long hold-off to back the pipe up
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (long_stall_go && !long_stall_done)
        begin
            m_tready <= 1'b0;
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LEN - 1)
                long_stall_done <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words outstanding",
                     cycle_count, open_count);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_point(int a, int b, int c);
        logic [IN_W-1:0] fa, fb, fc;
        fa = IN_W'(a);
        fb = IN_W'(b);
        fc = IN_W'(c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DW - 3 * IN_W){1'b0}}, fc, fb, fa};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
    endtask

    // mostly in [0,1] so the polynomials get exercised; some boundary values, the rest full range
    function automatic int pick_phase();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return $urandom_range(UNIT);
        if (sel == 6)
        begin
            case ($urandom_range(5))
                0: return 0;
                1: return UNIT;
                2: return -1;
                3: return UNIT + 1;
                4: return PMIN;
                default: return PMAX;
            endcase
        end
        return $urandom() & ((1 << IN_W) - 1);
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_point(pick_phase(), pick_phase(), pick_phase());
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: clamp regions, exact boundaries, p1 out of range, field extremes
        tx_idle_pct <= 14;
        rx_idle_pct <= 51;
        send_point(PMIN, 0, 0);
        send_point(-1, UNIT / 2, UNIT / 2);
        send_point(0, 0, UNIT);
        send_point(0, UNIT, 0);
        send_point(UNIT, 0, 0);
        send_point(UNIT, UNIT, UNIT);
        send_point(UNIT + 1, 0, 0);
        send_point(PMAX, PMAX, PMAX);
        send_point(UNIT / 2, UNIT / 2, 0);
        send_point(UNIT / 2, -1, UNIT / 2);
        send_point(UNIT / 2, UNIT + 1, 0);
        send_point(UNIT / 2, PMIN, PMAX);
        send_point(UNIT / 2, PMAX, PMIN);
        send_point(UNIT, PMIN, PMAX);
        send_point(UNIT / 2, UNIT / 2, PMIN);
        send_point(0, 0, PMIN);
        send_point(UNIT, UNIT, PMIN);
        send_point(UNIT, 0, PMAX);
        send_point(1, 1, 1);
        send_point(UNIT - 1, UNIT - 1, 1);
        send_point(21845, 21845, 21846);
        send_point(UNIT, PMIN, PMIN);
        send_point(0, UNIT, PMAX);
        send_point(UNIT, UNIT, PMAX);

        send_random(PHASE_ITEMS);
        tx_idle_pct <= 51;
        rx_idle_pct <= 14;
        send_random(PHASE_ITEMS);
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        long_stall_go <= 1'b1;
        send_random(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        while (open_count != 0)
            @(posedge clk);
        repeat (3 * tpi_pkg::STAGES) @(posedge clk);

        $display("Sent %0d points (24 directed, rest random under three idle mixes)",
                 sent_count);
        $display("Checked %0d result words, incl. a %0d-cycle output hold-off",
                 result_count, STALL_LEN);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/tpi_pkg.sv
rtl/tpi_mulrnd.sv
rtl/tpi_ctrl.sv
rtl/tpi_datapath.sv
rtl/tpi_out.sv
rtl/three_phase_interpolation_eval_top.sv
tb/sv/tpi_result_checker.sv
tb/sv/testbench.sv
